// ----- rtl/core/exp_ts_pkg.sv -----
// ----------------------------------------------------------------------------
// exp_ts_pkg
// shared widths and the command bundle for the exponential series block
// ----------------------------------------------------------------------------
package exp_ts_pkg;

	// field widths of the stream words
	localparam int BASE_W = 4;
	localparam int DEG_W  = 6;
	localparam int OUT_W  = 42;

	// headroom bits above the fraction: largest term is below 2^(FRAC_BITS+19)
	// for a base of 15, and the full sum below 2^(FRAC_BITS+22)
	localparam int TERM_GROWTH = 19;
	localparam int SUM_GROWTH  = 23;

	// controller to datapath commands
	typedef struct packed {
		logic             load;      // take a new word, term and sum to 1.0
		logic             mul;       // term times base into the divider
		logic             div_step;  // one restoring division step
		logic             acc;       // quotient becomes term, added to sum
		logic             emit;      // saturated sum into the output register
		logic [DEG_W-1:0] k;         // divisor of the running term
	} cmd_t;

endpackage

// ----- rtl/core/exp_ts_ctrl.sv -----
// ----------------------------------------------------------------------------
// exp_ts_ctrl
// sequencer: steps the term index, times the divider and owns the handshakes
// ----------------------------------------------------------------------------
module exp_ts_ctrl #(
	parameter int FRAC_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [exp_ts_pkg::DEG_W-1:0]  degree,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output exp_ts_pkg::cmd_t              cmd
);

	localparam int PROD_W = FRAC_BITS + exp_ts_pkg::TERM_GROWTH + exp_ts_pkg::BASE_W;
	localparam int CNT_W  = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ACC,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [exp_ts_pkg::DEG_W-1:0]   deg_q;
	logic [exp_ts_pkg::DEG_W-1:0]   k_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           m_valid_q;
	logic                           out_free;

	// output register can take a word when empty or being drained
	assign out_free = !m_valid_q || m_tready;

	// commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && s_tvalid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.acc      = (state_q == ST_ACC);
		cmd.emit     = (state_q == ST_EMIT) && out_free;
		cmd.k        = k_q;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			deg_q     <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// output valid: set by the write-back, cleared when taken
			if (cmd.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						deg_q   <= degree;
						k_q     <= exp_ts_pkg::DEG_W'(1);
						state_q <= (degree == '0) ? ST_EMIT : ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= CNT_W'(PROD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_ACC: begin
					if (k_q == deg_q) begin
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_q + exp_ts_pkg::DEG_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/exp_ts_dpath.sv -----
// ----------------------------------------------------------------------------
// exp_ts_dpath
// term register, multiplier, bit-serial divider and sum accumulator
// ----------------------------------------------------------------------------
module exp_ts_dpath #(
	parameter int FRAC_BITS = 20
) (
	input  logic                          clk,
	input  exp_ts_pkg::cmd_t              cmd,
	input  logic [exp_ts_pkg::BASE_W-1:0] base_value,
	output logic [exp_ts_pkg::OUT_W-1:0]  exp_result
);

	localparam int TERM_W = FRAC_BITS + exp_ts_pkg::TERM_GROWTH;
	localparam int PROD_W = TERM_W + exp_ts_pkg::BASE_W;
	localparam int SUM_W  = FRAC_BITS + exp_ts_pkg::SUM_GROWTH;
	localparam int K_W    = exp_ts_pkg::DEG_W;

	logic [exp_ts_pkg::BASE_W-1:0] base_q;
	logic [TERM_W-1:0]             term_q;
	logic [SUM_W-1:0]              sum_q;
	logic [PROD_W-1:0]             quo_q;
	logic [K_W-1:0]                rem_q;
	logic [exp_ts_pkg::OUT_W-1:0]  result_q;

	logic [PROD_W-1:0]             product;
	logic [K_W:0]                  trial;
	logic [K_W:0]                  trial_sub;
	logic                          fits;
	logic [TERM_W-1:0]             quotient;
	logic [exp_ts_pkg::OUT_W-1:0]  sum_sat;

	// term times base, narrow second operand
	assign product = PROD_W'(term_q) * PROD_W'(base_q);

	// restoring division step: bring down the next dividend bit
	assign trial     = {rem_q, quo_q[PROD_W-1]};
	assign trial_sub = trial - {1'b0, cmd.k};
	assign fits      = (trial >= {1'b0, cmd.k});
	assign quotient  = quo_q[TERM_W-1:0];

	// clamp the sum to the output field
	generate
		if (SUM_W > exp_ts_pkg::OUT_W) begin : g_sat
			assign sum_sat = (|sum_q[SUM_W-1:exp_ts_pkg::OUT_W]) ? '1
			                                                   : sum_q[exp_ts_pkg::OUT_W-1:0];
		end else begin : g_nosat
			assign sum_sat = exp_ts_pkg::OUT_W'(sum_q);
		end
	endgenerate

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_value;
			term_q <= TERM_W'(1) << FRAC_BITS;
			sum_q  <= SUM_W'(1) << FRAC_BITS;
		end
		if (cmd.mul) begin
			quo_q <= product;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? trial_sub[K_W-1:0] : trial[K_W-1:0];
		end
		if (cmd.acc) begin
			term_q <= quotient;
			sum_q  <= sum_q + SUM_W'(quotient);
		end
		if (cmd.emit) begin
			result_q <= sum_sat;
		end
	end

	assign exp_result = result_q;

endmodule

// ----- rtl/core/exp_taylor_series.sv -----
// ----------------------------------------------------------------------------
// exp_taylor_series
// truncated Taylor sum of exp(x) for a small integer x, unsigned fixed point
// ----------------------------------------------------------------------------
//  channel  | dir | payload (lowest bit up)
//  s_axis   | in  | base_value[3:0], degree[9:4], zero fill to 16 bits
//  m_axis   | out | exp_result[41:0], zero fill to 48 bits
//
//  one word at a time: each term after term 0 takes a multiply step, a
//  divider pass by the term index at one quotient bit per cycle and an
//  accumulate step
//  reset clears the sequencer and output valid; no state across words
//  a new word is taken while a finished result waits in the output register
//  a stalled output holds the sequencer only at the write-back step
// ----------------------------------------------------------------------------
module exp_taylor_series #(
	parameter int FRAC_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // base_value[3:0], degree[9:4]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // exp_result[41:0]
);

	localparam logic [exp_ts_pkg::OUT_W-1:0] ONE = exp_ts_pkg::OUT_W'(1) << FRAC_BITS;

	exp_ts_pkg::cmd_t               cmd;
	logic [exp_ts_pkg::OUT_W-1:0]   exp_result;

	// sequencer
	exp_ts_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.degree   (s_tdata[9:4]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// arithmetic
	exp_ts_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.cmd        (cmd),
		.base_value (s_tdata[3:0]),
		.exp_result (exp_result)
	);

	assign m_tdata = {6'b0, exp_result};

	// at most one datapath command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.div_step, cmd.acc, cmd.emit}))
		else $error("more than one datapath command");

	// a taken word closes the input until its result is written
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open while a word is in work");

	// every result holds at least term 0
	a_result_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> exp_result >= ONE)
		else $error("result below 1.0");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the exponential Taylor series block: words of base
// and degree go in, each returned sum is compared with a local integer model
// of the term recurrence, under three mixes of sender and receiver idling
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAC_BITS   = 20;
	localparam int N_RAND_A    = 60;
	localparam int N_RAND_B    = 70;
	localparam int N_RAND_C    = 75;
	// drain wait sized for the slowest word, 63 terms, plus a margin
	localparam int DRAIN_CYC   = 63 * (FRAC_BITS + 25) + 200;
	localparam int STALL_LIMIT = 20000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [exp_ts_pkg::DEG_W-1:0]  degree;
		logic [exp_ts_pkg::BASE_W-1:0] base_value;
	} series_req_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // base_value[3:0], degree[9:4]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // exp_result[41:0]

	series_req_t                    pending_reqs[$];
	logic [exp_ts_pkg::OUT_W-1:0]   expected_sums[$];
	series_req_t                    cur_req;
	int                     snd_idle_pct = 36;
	int                     rcv_idle_pct = 55;
	int                     words_in     = 0;
	int                     sums_checked = 0;
	int                     mismatches   = 0;
	int                     zero_bases   = 0;
	int                     zero_degrees = 0;
	int                     quiet_cycles = 0;

	exp_taylor_series #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// series sum by the floor recurrence, saturated to the output width
	function automatic logic [exp_ts_pkg::OUT_W-1:0] taylor_exp_sum(
			input logic [exp_ts_pkg::BASE_W-1:0] x,
			input logic [exp_ts_pkg::DEG_W-1:0] deg);
		bit [63:0] term;
		bit [63:0] total;
		bit [63:0] out_max;
		out_max = {{(64-exp_ts_pkg::OUT_W){1'b0}}, {exp_ts_pkg::OUT_W{1'b1}}};
		term  = 64'd1 << FRAC_BITS;
		total = term;
		for (int k = 1; k <= deg; k++) begin
			term  = (term * 64'(x)) / 64'(k);
			total = total + term;
		end
		if (total > out_max)
			total = out_max;
		return total[exp_ts_pkg::OUT_W-1:0];
	endfunction

	// sender: one word held until taken, random gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_sums.push_back(taylor_exp_sum(cur_req.base_value, cur_req.degree));
				words_in++;
				if (cur_req.base_value == '0)
					zero_bases++;
				if (cur_req.degree == '0)
					zero_degrees++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					cur_req  = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, cur_req.degree, cur_req.base_value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, each taken word checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word: exp_result %0d",
							m_tdata[exp_ts_pkg::OUT_W-1:0]);
				end else begin
					logic [exp_ts_pkg::OUT_W-1:0] want;
					want = expected_sums.pop_front();
					sums_checked++;
					if (m_tdata[exp_ts_pkg::OUT_W-1:0] !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("exp_result mismatch: expected %0d got %0d",
								want, m_tdata[exp_ts_pkg::OUT_W-1:0]);
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic queue_req(input int x, input int deg);
		series_req_t r;
		r.base_value = x[exp_ts_pkg::BASE_W-1:0];
		r.degree     = deg[exp_ts_pkg::DEG_W-1:0];
		pending_reqs.push_back(r);
	endtask

	// mostly short series, a few long ones, base over the whole field
	task automatic queue_random(input int n);
		int pick;
		int deg;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				deg = $urandom_range(0, 15);
			else if (pick < 95)
				deg = $urandom_range(16, 40);
			else
				deg = $urandom_range(41, 63);
			queue_req($urandom_range(0, 15), deg);
		end
	endtask

	// hold off until every word is sent and every sum has come back
	task automatic wait_all_done();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_sums.size() != 0);
	endtask

	// stimulus and end of run
	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: one, fifteen and zero bases, degree zero, longest series
		queue_req(1, 0);   queue_req(15, 0);  queue_req(0, 0);   queue_req(0, 63);
		queue_req(15, 63); queue_req(1, 63);  queue_req(15, 1);  queue_req(8, 1);
		queue_req(7, 2);   queue_req(2, 10);  queue_req(4, 5);   queue_req(15, 31);
		queue_req(9, 32);  queue_req(10, 20); queue_req(5, 16);  queue_req(3, 8);
		queue_req(12, 48); queue_req(15, 40); queue_req(6, 3);   queue_req(11, 7);
		queue_req(13, 62); queue_req(14, 12);
		wait_all_done();

		queue_random(N_RAND_A);
		wait_all_done();

		snd_idle_pct = 55;
		rcv_idle_pct = 36;
		queue_random(N_RAND_B);
		wait_all_done();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		queue_random(N_RAND_C);
		wait_all_done();

		repeat (DRAIN_CYC) @(negedge clk);
		if (expected_sums.size() != 0)
			mismatches += expected_sums.size();

		$display("sent %0d words (%0d with base zero, %0d with degree zero), checked %0d sums",
			words_in, zero_bases, zero_degrees, sums_checked);
		$display("bases 0..15 and degrees 0..63 under three idling mixes, %0d errors",
			mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
